@@ rtl/core/wsfp_pkg.sv @@
// Shared types and constants for the WebSocket frame parser.
package wsfp_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_B0    = 3'd0;
    localparam logic [2:0] PH_B1    = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    // 7-bit length codes that announce an extended length field
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Extended length / key byte counts (3-bit counter, 8 wraps to 0)
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_BYTES = 3'd0;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int TDATA_W = 80;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [7:0]  data;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/wsfp_deframer.sv @@
// Header/payload parse state machine: one stream byte in, at most one result out.
module wsfp_deframer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        stream_byte,
    output wsfp_pkg::result_t result,
    output logic [2:0]        phase
);

    logic [2:0]  phase_reg,  phase_next;
    logic        fin_reg,    fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] len_reg,    len_next;
    logic [31:0] key_reg,    key_next;
    logic [2:0]  fbc_reg,    fbc_next;
    logic [63:0] pc_reg,     pc_next;

    // shared "header finished" and "length finished" paths
    logic        len_done;
    logic        hdr_done;
    logic [2:0]  fbc_inc;
    logic [63:0] pc_inc;
    logic [7:0]  key_byte;
    logic [7:0]  data_byte;

    assign fbc_inc = fbc_reg + 3'd1;
    assign pc_inc  = pc_reg + 64'd1;

    always_comb begin
        unique case (pc_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        data_byte = masked_reg ? (stream_byte ^ key_byte) : stream_byte;
    end

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        fbc_next    = fbc_reg;
        pc_next     = pc_reg;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        result      = '0;

        if (byte_accept) begin
            unique case (phase_reg)
                wsfp_pkg::PH_B1: begin
                    masked_next = stream_byte[7];
                    fbc_next    = 3'd0;
                    if (stream_byte[6:0] == wsfp_pkg::LEN_CODE_16) begin
                        len_next   = '0;
                        phase_next = wsfp_pkg::PH_EXT16;
                    end else if (stream_byte[6:0] == wsfp_pkg::LEN_CODE_64) begin
                        len_next   = '0;
                        phase_next = wsfp_pkg::PH_EXT64;
                    end else begin
                        len_next = {57'd0, stream_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
                    len_next = {len_reg[55:0], stream_byte};
                    fbc_next = fbc_inc;
                    if (fbc_inc == ((phase_reg == wsfp_pkg::PH_EXT16) ?
                                    wsfp_pkg::EXT16_BYTES : wsfp_pkg::EXT64_BYTES)) begin
                        len_done = 1'b1;
                    end
                end
                wsfp_pkg::PH_KEY: begin
                    key_next = {key_reg[23:0], stream_byte};
                    fbc_next = fbc_inc;
                    if (fbc_inc == wsfp_pkg::KEY_BYTES) begin
                        hdr_done = 1'b1;
                    end
                end
                wsfp_pkg::PH_DATA: begin
                    pc_next       = pc_inc;
                    result.valid  = 1'b1;
                    result.kind   = wsfp_pkg::KIND_PAYLOAD;
                    result.data   = data_byte;
                    result.last   = (pc_inc == len_reg);
                    if (pc_inc == len_reg) begin
                        phase_next = wsfp_pkg::PH_B0;
                    end
                end
                default: begin
                    // first header byte; unused codes land here as well
                    fin_next    = stream_byte[7];
                    opcode_next = stream_byte[3:0];
                    phase_next  = wsfp_pkg::PH_B1;
                end
            endcase

            // length known: collect the key, or close the header now
            if (len_done) begin
                if (masked_next) begin
                    fbc_next   = 3'd0;
                    key_next   = '0;
                    phase_next = wsfp_pkg::PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                result.valid = 1'b1;
                result.kind  = wsfp_pkg::KIND_HEADER;
                result.data  = '0;
                result.last  = (len_next == 64'd0);
                pc_next      = '0;
                phase_next   = (len_next == 64'd0) ? wsfp_pkg::PH_B0 : wsfp_pkg::PH_DATA;
            end

            result.fin    = fin_next;
            result.opcode = opcode_next;
            result.masked = masked_next;
            result.length = len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsfp_pkg::PH_B0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            key_reg    <= '0;
            fbc_reg    <= '0;
            pc_reg     <= '0;
        end else begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            fbc_reg    <= fbc_next;
            pc_reg     <= pc_next;
        end
    end

    assign phase = phase_reg;

endmodule

@@ rtl/core/websocket_frame_parser_unit.sv @@
// Top level of the WebSocket frame parser: stream ports and result register.
//
// Usage:
//   s_axis: raw frame stream, one byte per transfer in s_tdata[7:0].
//   m_axis: one result per header and one per payload byte.
//     m_tuser = item kind (0 header summary, 1 payload byte).
//     m_tlast = last result of the frame (a zero-length frame's header
//               result carries it).
//     m_tdata = fin, opcode, masked flag, 64-bit length, unmasked payload byte.
//   Header bytes (first two, extended length, masking key) yield no result;
//   the header summary appears with the transfer of the last header byte.
// Latency: a result is valid the cycle after the byte that causes it.
// Throughput: one byte per cycle while s_tready is high; the parse state updates
//   in a single pass from byte and state registers into one result register.
// Reset: synchronous, active low; the parser waits for a frame's first byte
//   and the result register is empty.
// Stall: while a result sits unread, s_tready follows m_tready, so a byte is
//   taken in the same cycle the held result leaves. Partial frames just wait.
module websocket_frame_parser_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] stream_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wsfp_pkg::TDATA_W-1:0] m_tdata,   // [0] final_fragment,
                                                    // [4:1] frame_opcode,
                                                    // [5] was_masked,
                                                    // [69:6] frame_length,
                                                    // [77:70] payload_byte,
                                                    // [79:78] zero
    output logic                         m_tuser,   // [0] item_kind
    output logic                         m_tlast    // frame_end
);

    logic              s_accept;
    wsfp_pkg::result_t res;
    logic [2:0]        phase;

    logic              m_tvalid_reg, m_tvalid_next;
    wsfp_pkg::result_t out_reg,      out_next;

    // a byte can enter whenever the result slot is free or leaving
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    wsfp_deframer u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .stream_byte (s_tdata),
        .result      (res),
        .phase       (phase)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (s_accept) begin
            m_tvalid_next = res.valid;
            out_next      = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00, out_reg.data, out_reg.length, out_reg.masked,
                       out_reg.opcode, out_reg.fin};

`ifndef SYNTHESIS
    // a header result only closes the frame when the frame is empty
    a_hdr_last_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == wsfp_pkg::KIND_HEADER) && m_tlast
            |-> (m_tdata[69:6] == 64'd0))
        else $error("header marked last with nonzero length");

    // payload only flows for frames with a nonzero length
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == wsfp_pkg::KIND_PAYLOAD) |-> (m_tdata[69:6] != 64'd0))
        else $error("payload result in a zero-length frame");

    // every byte taken in the data phase produces a result
    a_data_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (phase == wsfp_pkg::PH_DATA)
            |=> m_tvalid && (m_tuser == wsfp_pkg::KIND_PAYLOAD))
        else $error("payload byte produced no result");

    // after a frame's last payload byte the parser waits for a new header
    a_last_to_b0: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (phase == wsfp_pkg::PH_DATA) && res.last
            |=> (phase == wsfp_pkg::PH_B0))
        else $error("parser did not return to header start");
`endif

endmodule
